### rtl/masked_event_ring_queue_top_defines.svh
`ifndef MASKED_EVENT_RING_QUEUE_TOP_DEFINES_SVH
`define MASKED_EVENT_RING_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define EMRQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EMRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/emrq_pkg.sv
`default_nettype none
package emrq_pkg;

    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int NUM_TYPES_DEF   = 32;
    localparam int MAX_REQUEST_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam int TYPE_W  = 5;
    localparam int FDATA_W = 32;
    localparam int MASK_W  = 32;
    localparam int REQ_W   = 5;
    localparam int CNT_W   = 5;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_PEEK  = 2'd1,
        CMD_GET   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        OP_HOLD  = 4'b0001,
        OP_ROT   = 4'b0010,
        OP_SHIFT = 4'b0100,
        OP_ADD   = 4'b1000
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_STAT = 3'b100
    } state_t;

endpackage
`default_nettype wire

### rtl/emrq_cell.sv
`default_nettype none
module emrq_cell #(
    parameter int W   = 37,
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  wire logic               aclk,
    input  wire emrq_pkg::cell_ctl_t ctl,
    input  wire logic [CW-1:0]      cnt,
    input  wire logic [W-1:0]       right_d,
    input  wire logic [W-1:0]       head_d,
    input  wire logic [W-1:0]       new_d,
    output logic      [W-1:0]       q
);
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [W-1:0]  q_reg;
    logic [W-1:0]  q_next;
    logic [CW-1:0] cnt_m1;

    assign cnt_m1 = cnt - CW'(1);

    always_comb begin
        q_next = q_reg;
        case (ctl.op)
            emrq_pkg::OP_ROT: begin
                if (MY_IDX == cnt_m1) begin
                    q_next = head_d;
                end else if (MY_IDX < cnt_m1) begin
                    q_next = right_d;
                end
            end
            emrq_pkg::OP_SHIFT: q_next = right_d;
            emrq_pkg::OP_ADD: begin
                if (MY_IDX == cnt) begin
                    q_next = new_d;
                end
            end
            default: q_next = q_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;
endmodule
`default_nettype wire

### rtl/masked_event_ring_queue_top.sv
// masked event queue: a chain of entry cells, oldest event in the first cell
// s_ channel takes one command item: s_tuser is the command, s_tdata the
//   event type, payload, type mask and request count
// m_ channel gives one item per matched event (m_tuser high), then one status
//   item (m_tuser low, m_tlast high) carrying the count added or delivered
// add, clear and any command while disabled: one status item, loaded in the
//   status state once the output register is free
// peek and get: the chain rotates once per held event, examining the first
//   cell each cycle while the output is not stalled, then the status item is
//   loaded; a matched get removes the entry by shifting the chain down
// a new command is taken only after the status item has been loaded
// a stalled receiver holds the output register and freezes the scan
// reset empties the queue and sets the enable register; the stored entries
//   are not cleared and need no clearing pass
// apb register 0 at address 0: bit 0 enable
`default_nettype none
`include "masked_event_ring_queue_top_defines.svh"
module masked_event_ring_queue_top #(
    parameter int QUEUE_DEPTH = emrq_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_TYPES   = emrq_pkg::NUM_TYPES_DEF,
    parameter int MAX_REQUEST = emrq_pkg::MAX_REQUEST_DEF,
    parameter int DATA_WIDTH  = emrq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // event_type, event_data, type_mask, request_count, zero fill
    input  wire logic [79:0] s_tdata,
    // command
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_type, out_data, count, zero fill
    output logic [47:0]      m_tdata,
    // is_event
    output logic             m_tuser,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int CW = $clog2(QUEUE_DEPTH);
    localparam int RW = $clog2(MAX_REQUEST + 1);
    localparam int TW = emrq_pkg::TYPE_W;
    localparam int W  = TW + DATA_WIDTH;
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH - 1);

    emrq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    rem_reg, rem_next;
    logic [RW-1:0]    used_reg, used_next;
    logic [RW-1:0]    req_reg, req_next;
    logic             get_reg, get_next;
    logic [31:0]      mask_reg, mask_next;
    logic             en_reg;
    logic             ov_reg, ov_next;
    logic             oev_reg, oev_next;
    logic [TW-1:0]    otype_reg, otype_next;
    logic [31:0]      odata_reg, odata_next;
    logic [RW-1:0]    ocnt_reg, ocnt_next;

    emrq_pkg::cell_ctl_t ctl;
    logic [W-1:0]        cell_q [QUEUE_DEPTH];
    logic [W-1:0]        new_d;
    logic [W-1:0]        head_d;
    logic [TW-1:0]       head_type;
    logic                hit;
    logic                out_free;
    logic                accept;
    emrq_pkg::cmd_t      cmd_in;
    logic [4:0]          req_in;

    assign cmd_in   = emrq_pkg::cmd_t'(s_tuser);
    assign req_in   = s_tdata[73:69];
    assign new_d    = {s_tdata[4:0], DATA_WIDTH'(s_tdata[36:5])};
    assign head_d   = cell_q[0];
    assign head_type = head_d[W-1:DATA_WIDTH];
    assign s_tready = (state_reg == emrq_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !ov_reg || m_tready;
    assign hit      = (int'(head_type) < NUM_TYPES) && mask_reg[head_type]
                      && (used_reg < req_reg);

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic [W-1:0] right_d;
            if (gi == QUEUE_DEPTH - 1) begin : g_end
                assign right_d = '0;
            end else begin : g_mid
                assign right_d = cell_q[gi+1];
            end
            emrq_cell #(.W(W), .CW(CW), .IDX(gi)) u_cell (
                .aclk    (aclk),
                .ctl     (ctl),
                .cnt     (cnt_reg),
                .right_d (right_d),
                .head_d  (head_d),
                .new_d   (new_d),
                .q       (cell_q[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        used_next  = used_reg;
        req_next   = req_reg;
        get_next   = get_reg;
        mask_next  = mask_reg;
        ov_next    = ov_reg && !m_tready;
        oev_next   = oev_reg;
        otype_next = otype_reg;
        odata_next = odata_reg;
        ocnt_next  = ocnt_reg;
        ctl.op     = emrq_pkg::OP_HOLD;
        case (state_reg)
            emrq_pkg::ST_IDLE: begin
                if (accept) begin
                    used_next  = '0;
                    mask_next  = s_tdata[68:37];
                    get_next   = (cmd_in == emrq_pkg::CMD_GET);
                    req_next   = (int'(req_in) > MAX_REQUEST) ? RW'(MAX_REQUEST)
                                                              : RW'(req_in);
                    state_next = emrq_pkg::ST_STAT;
                    if (en_reg) begin
                        case (cmd_in)
                            emrq_pkg::CMD_ADD: begin
                                if (cnt_reg != FULL_CNT) begin
                                    ctl.op    = emrq_pkg::OP_ADD;
                                    cnt_next  = cnt_reg + CW'(1);
                                    used_next = RW'(1);
                                end
                            end
                            emrq_pkg::CMD_CLEAR: cnt_next = '0;
                            default: begin
                                rem_next   = cnt_reg;
                                state_next = emrq_pkg::ST_SCAN;
                            end
                        endcase
                    end
                end
            end
            emrq_pkg::ST_SCAN: begin
                if (out_free) begin
                    if (rem_reg == '0) begin
                        state_next = emrq_pkg::ST_STAT;
                    end else begin
                        rem_next = rem_reg - CW'(1);
                        if (hit) begin
                            used_next  = used_reg + RW'(1);
                            ov_next    = 1'b1;
                            oev_next   = 1'b1;
                            otype_next = head_type;
                            odata_next = 32'(head_d[DATA_WIDTH-1:0]);
                            ocnt_next  = '0;
                        end
                        if (hit && get_reg) begin
                            ctl.op   = emrq_pkg::OP_SHIFT;
                            cnt_next = cnt_reg - CW'(1);
                        end else begin
                            ctl.op = emrq_pkg::OP_ROT;
                        end
                    end
                end
            end
            emrq_pkg::ST_STAT: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    oev_next   = 1'b0;
                    otype_next = '0;
                    odata_next = '0;
                    ocnt_next  = used_reg;
                    state_next = emrq_pkg::ST_IDLE;
                end
            end
            default: state_next = emrq_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= emrq_pkg::ST_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
            en_reg    <= 1'b1;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            used_reg  <= used_next;
            ov_reg    <= ov_next;
            if (psel && penable && pwrite && !paddr[2]) begin
                en_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        get_reg   <= get_next;
        mask_reg  <= mask_next;
        oev_reg   <= oev_next;
        otype_reg <= otype_next;
        odata_reg <= odata_next;
        ocnt_reg  <= ocnt_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = oev_reg;
    assign m_tlast  = !oev_reg;
    assign m_tdata  = {6'd0, emrq_pkg::CNT_W'(ocnt_reg), odata_reg, otype_reg};
    assign prdata   = {31'd0, en_reg};
    assign pready   = 1'b1;

    `EMRQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= FULL_CNT, "queue count beyond capacity")
    `EMRQ_ASSERT_NOW(a_used_bound, state_reg == emrq_pkg::ST_SCAN, used_reg <= req_reg, "delivered more than requested")
    `EMRQ_ASSERT_NEXT(a_add_grow, accept && en_reg && cmd_in == emrq_pkg::CMD_ADD && cnt_reg != FULL_CNT, cnt_reg == $past(cnt_reg) + CW'(1), "add did not store the event")
    `EMRQ_ASSERT_NEXT(a_scan_end, state_reg == emrq_pkg::ST_SCAN && out_free && rem_reg == '0, state_reg == emrq_pkg::ST_STAT, "scan did not close with status")
endmodule
`default_nettype wire
